/* design/vlbp_pkg.sv */
// ----------------------------------------------------------------------------
// vlbp_pkg
// Shared constants and types for the variable-length bit packer.
// ----------------------------------------------------------------------------
package vlbp_pkg;

  localparam int unsigned ACC_WIDTH_DEF = 64;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned CODE_W        = 64;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned BYTE_W        = 8;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* design/vlbp_front.sv */
// ----------------------------------------------------------------------------
// vlbp_front
// Accepts codes, packs them LSB first into the accumulator and pushes each
// completed word into the word queue.
// ----------------------------------------------------------------------------
module vlbp_front #(
  parameter int unsigned ACC_WIDTH = vlbp_pkg::ACC_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vlbp_pkg::CODE_W-1:0]   code_value_i,
  input  logic [vlbp_pkg::LEN_W-1:0]    code_length_i,
  input  vlbp_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output logic [ACC_WIDTH-1:0]          push_word_o
);

  localparam int unsigned FW = $clog2(ACC_WIDTH + 1);

  logic [ACC_WIDTH-1:0]        acc_q, acc_d;
  logic [FW-1:0]               free_q, free_d;
  logic                        accept;
  logic [FW-1:0]               len_sat;
  logic [FW-1:0]               used;
  logic [FW-1:0]               rem;
  logic [vlbp_pkg::CODE_W-1:0] code_mask;
  logic [vlbp_pkg::CODE_W-1:0] code_masked;
  logic [vlbp_pkg::CODE_W-1:0] code_shl;
  logic [vlbp_pkg::CODE_W-1:0] code_rest;
  logic [ACC_WIDTH-1:0]        word;
  logic                        complete;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;

  always_comb begin
    if (code_length_i > vlbp_pkg::LEN_W'(ACC_WIDTH)) begin
      len_sat = FW'(ACC_WIDTH);
    end else begin
      len_sat = FW'(code_length_i);
    end
    code_mask   = ~({vlbp_pkg::CODE_W{1'b1}} << len_sat);
    code_masked = code_value_i & code_mask;
    used        = FW'(ACC_WIDTH) - free_q;
    code_shl    = code_masked << used;
    word        = acc_q | ACC_WIDTH'(code_shl);
    complete    = (len_sat >= free_q);
    rem         = len_sat - free_q;
    code_rest   = code_masked >> free_q;
  end

  always_comb begin
    acc_d  = acc_q;
    free_d = free_q;
    if (accept) begin
      if (complete) begin
        acc_d  = ACC_WIDTH'(code_rest);
        free_d = FW'(ACC_WIDTH) - rem;
      end else begin
        acc_d  = word;
        free_d = free_q - len_sat;
      end
    end
  end

  assign push_o      = accept & complete;
  assign push_word_o = word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      free_q <= FW'(ACC_WIDTH);
    end else begin
      acc_q  <= acc_d;
      free_q <= free_d;
    end
  end

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q != '0) && (free_q <= FW'(ACC_WIDTH)))
    else $error("free bit count out of range");

endmodule

/* design/vlbp_fifo.sv */
// ----------------------------------------------------------------------------
// vlbp_fifo
// Short queue of completed words between the packer and the serializer.
// ----------------------------------------------------------------------------
module vlbp_fifo #(
  parameter int unsigned WIDTH = vlbp_pkg::ACC_WIDTH_DEF,
  parameter int unsigned DEPTH = vlbp_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   push_word_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   head_o,
  output vlbp_pkg::q_stat_t  stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full || pop_i))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

/* design/vlbp_ser.sv */
// ----------------------------------------------------------------------------
// vlbp_ser
// Sends the queue head out one byte per transaction, low byte first, and
// marks the last byte of each word.
// ----------------------------------------------------------------------------
module vlbp_ser #(
  parameter int unsigned ACC_WIDTH = vlbp_pkg::ACC_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ACC_WIDTH-1:0]          head_i,
  input  vlbp_pkg::q_stat_t             q_stat_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vlbp_pkg::BYTE_W-1:0]   packed_byte_o,
  output logic                          last_of_word_o
);

  localparam int unsigned NB   = (ACC_WIDTH + 7) / 8;
  localparam int unsigned IW   = $clog2(NB);
  localparam int unsigned PADW = NB * 8;

  logic [IW-1:0]               idx_q, idx_d;
  logic                        valid_q, valid_d;
  logic [vlbp_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                        last_q, last_d;
  logic [PADW-1:0]             padded;
  logic                        adv;
  logic                        idx_last;

  assign padded   = PADW'(head_i);
  assign adv      = ~valid_q | ~out_stall_i;
  assign idx_last = (idx_q == IW'(NB - 1));
  assign pop_o    = adv & ~q_stat_i.empty & idx_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (adv) begin
      valid_d = ~q_stat_i.empty;
      if (!q_stat_i.empty) begin
        byte_d = padded[idx_q*8 +: 8];
        last_d = idx_last;
        idx_d  = idx_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign packed_byte_o  = byte_q;
  assign last_of_word_o = last_q;

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (idx_q == '0))
    else $error("byte index not rewound after last byte");

endmodule

/* design/variable_length_bit_packer.sv */
// ----------------------------------------------------------------------------
// variable_length_bit_packer
// LSB-first packer of variable-length codes into bytes of full words.
// ----------------------------------------------------------------------------
// One code (0..64 bits, longer lengths clip to ACC_WIDTH) is accepted every
// cycle while the queue is not full; masking, shifting into the accumulator
// and word completion happen in that cycle. Each completed word goes into a
// two-entry word queue and leaves as (ACC_WIDTH+7)/8 byte transactions, one
// per cycle while out_stall_i is low, so the output byte register sets the
// long-run rate: a stream that completes a word every code sustains one code
// per eight byte transactions at ACC_WIDTH = 64. in_stall_o is high while the
// queue is full, and then every code waits, even one that completes no word.
module variable_length_bit_packer #(
  parameter int unsigned ACC_WIDTH   = vlbp_pkg::ACC_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = vlbp_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vlbp_pkg::CODE_W-1:0]   code_value_i,
  input  logic [vlbp_pkg::LEN_W-1:0]    code_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vlbp_pkg::BYTE_W-1:0]   packed_byte_o,
  output logic                          last_of_word_o
);

  vlbp_pkg::q_stat_t    q_stat;
  logic                 push;
  logic [ACC_WIDTH-1:0] push_word;
  logic                 pop;
  logic [ACC_WIDTH-1:0] head;

  vlbp_front #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .code_value_i  (code_value_i),
    .code_length_i (code_length_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_word_o   (push_word)
  );

  vlbp_fifo #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  vlbp_ser #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_byte_o  (packed_byte_o),
    .last_of_word_o (last_of_word_o)
  );

endmodule

/* tb/sv/variable_length_bit_packer_test.sv */
// ----------------------------------------------------------------------------
// variable_length_bit_packer_test
// Self-checking bench for the LSB-first variable-length bit packer.
// Codes are sent in bursts with random gaps while the byte side stalls in
// changing patterns. A scoreboard packs every accepted code into its own
// accumulator and checks each byte transaction against the oldest one due.
// ----------------------------------------------------------------------------
module variable_length_bit_packer_test;

  localparam int unsigned ACC_W        = vlbp_pkg::ACC_WIDTH_DEF;
  localparam int unsigned RANDOM_CODES = 430;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  class code_packing_scoreboard;
    typedef struct {
      logic [vlbp_pkg::BYTE_W-1:0] packed_byte;
      logic                        last_of_word;
    } byte_result_t;

    byte_result_t                expected_bytes[$];
    logic [vlbp_pkg::CODE_W-1:0] acc_bits;
    int unsigned                 free_bits;
    int unsigned                 errors;

    function new();
      acc_bits  = '0;
      free_bits = ACC_W;
      errors    = 0;
    endfunction

    function logic [63:0] low_mask(int unsigned n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void pack_code(logic [vlbp_pkg::CODE_W-1:0] value,
                            logic [vlbp_pkg::LEN_W-1:0]  length);
      int unsigned   len;
      int unsigned   used;
      int unsigned   rem;
      int unsigned   nbytes;
      logic [63:0]   val;
      logic [63:0]   word;
      logic [63:0]   rest;
      byte_result_t  r;
      len = (length > ACC_W) ? ACC_W : length;
      val = value & low_mask(len);
      used = ACC_W - free_bits;
      if (len < free_bits) begin
        acc_bits  = (acc_bits | (val << used)) & low_mask(ACC_W);
        free_bits = free_bits - len;
        return;
      end
      word      = (acc_bits | (val << used)) & low_mask(ACC_W);
      rem       = len - free_bits;
      rest      = (free_bits >= 64) ? 64'd0 : (val >> free_bits);
      acc_bits  = rest & low_mask(rem);
      free_bits = ACC_W - rem;
      nbytes    = (ACC_W + 7) / 8;
      for (int unsigned k = 0; k < nbytes; k++) begin
        r.packed_byte  = word[8*k +: 8];
        r.last_of_word = (k + 1 == nbytes);
        expected_bytes.push_back(r);
      end
    endfunction

    function void compare_byte(logic [vlbp_pkg::BYTE_W-1:0] packed_byte,
                               logic                        last_of_word);
      byte_result_t exp_r;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte transaction: packed_byte %0h last_of_word %0b",
               packed_byte, last_of_word);
        errors++;
        return;
      end
      exp_r = expected_bytes.pop_front();
      if (packed_byte !== exp_r.packed_byte) begin
        $error("packed_byte mismatch: expected %0h, actual %0h",
               exp_r.packed_byte, packed_byte);
        errors++;
      end
      if (last_of_word !== exp_r.last_of_word) begin
        $error("last_of_word mismatch: expected %0b, actual %0b",
               exp_r.last_of_word, last_of_word);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic [vlbp_pkg::CODE_W-1:0] code_value_i  = '0;
  logic [vlbp_pkg::LEN_W-1:0]  code_length_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic [vlbp_pkg::BYTE_W-1:0] packed_byte_o;
  logic                        last_of_word_o;

  code_packing_scoreboard sb = new();

  stall_mode_e stall_mode  = STALL_NONE;
  int unsigned stall_left  = 0;
  logic [2:0]  stall_phase = '0;

  variable_length_bit_packer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_value_i   (code_value_i),
    .code_length_i  (code_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_byte_o  (packed_byte_o),
    .last_of_word_o (last_of_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.pack_code(code_value_i, code_length_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.compare_byte(packed_byte_o, last_of_word_o);
    end
  end

  // Byte-side backpressure: the mode is redrawn at random whenever its countdown runs out.
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 3'd1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: out_stall_i <= (stall_phase < 3'd3);
      default:        out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  task automatic send_code(input logic [vlbp_pkg::CODE_W-1:0] value,
                           input logic [vlbp_pkg::LEN_W-1:0]  length);
    in_valid_i    <= 1'b1;
    code_value_i  <= value;
    code_length_i <= length;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned                sent;
    int unsigned                burst;
    int unsigned                sel;
    bit                         drained;
    logic [vlbp_pkg::LEN_W-1:0] len;
    sent    = 0;
    drained = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero length, with and without garbage
    send_code(64'h0, 7'd0);
    send_code('1, 7'd0);
    // exact full words
    send_code('1, 7'd64);
    send_code(64'h0, 7'd64);
    send_code(64'h8000_0000_0000_0001, 7'd64);
    // partial word, then saturated lengths that overflow
    send_code('1, 7'd3);
    send_code(64'h0, 7'd3);
    send_code(64'h5, 7'd3);
    send_code('1, 7'd127);
    send_code(64'hDEAD_BEEF_CAFE_F00D, 7'd65);
    send_code(64'h0123_4567_89AB_CDEF, 7'd100);
    // 63-bit and 1-bit codes on top of a partial word
    send_code('1, 7'd63);
    send_code('1, 7'd1);
    // overflow by a few bits
    send_code(64'h5555_5555_5555_5555, 7'd60);
    send_code(64'hAAAA_AAAA_AAAA_AAAA, 7'd10);
    // bits above length are masked
    send_code(64'hFFFF_FFFF_FFFF_FFE0, 7'd5);
    send_code(64'hFFFF_FFFF_0000_1234, 7'd32);
    send_code(64'h1234_5678_9ABC_DEF0, 7'd32);
    send_code(64'h0, 7'd1);
    send_code(64'h1, 7'd1);
    send_code('1, 7'd64);
    wait_until_drained();

    while (sent < RANDOM_CODES) begin
      burst = $urandom_range(1, 32);
      for (int unsigned i = 0; i < burst && sent < RANDOM_CODES; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) len = 7'd0;
        else if (sel < 22) len = 7'd64;
        else if (sel < 28) len = vlbp_pkg::LEN_W'($urandom_range(65, 127));
        else len = vlbp_pkg::LEN_W'($urandom_range(1, 63));
        send_code({$urandom, $urandom}, len);
        sent++;
      end
      if (!drained && sent >= RANDOM_CODES / 2) begin
        wait_until_drained();
        drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end

    wait_until_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
